FILE: hw/rtl/f2i_pkg.sv
package f2i_pkg;

   typedef enum logic [1:0] {
      OP_S2I32 = 2'd0,
      OP_S2I64 = 2'd1,
      OP_D2I32 = 2'd2,
      OP_D2I64 = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] operand_bits;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result;
   } rsp_type;

   localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX32 = 64'h0000_0000_7fff_ffff;
   localparam logic [63:0] MIN32 = 64'hffff_ffff_8000_0000;

   // Classification code carried from decode to the final stage.
   typedef enum logic [1:0] {
      CLS_ZERO = 2'd0,
      CLS_SAT  = 2'd1,
      CLS_NUM  = 2'd2
   } cls_type;

endpackage

FILE: hw/rtl/f2i_if.sv
interface f2i_req_if;
   import f2i_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface f2i_rsp_if;
   import f2i_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/float_to_int_saturating_convert_top.sv
// A request beat passes through the stage 1, stage 2 and stage 3 registers to its response beat.
// Throughput: one beat per cycle; the pipeline advances whenever its output
// register is empty or being taken, so a stall holds every stage in place.
// Reset (synchronous, active high) clears all stage valid bits; payload
// registers are not reset.
module float_to_int_saturating_convert_top (
   input logic clock,
   input logic reset,
   f2i_req_if.sink   req,
   f2i_rsp_if.source rsp
);
   import f2i_pkg::*;

   logic advance;
   logic v1_ff, v2_ff, v3_ff;

   // Stage 1 registers: decoded fields.
   logic        neg1_ff;
   logic        wide1_ff;
   cls_type     cls1_ff;
   logic [52:0] mant1_ff;
   logic [5:0]  e1_ff;
   logic        dbl1_ff;

   // Stage 2 registers: magnitude.
   logic        neg2_ff;
   logic        wide2_ff;
   cls_type     cls2_ff;
   logic [62:0] mag2_ff;

   logic [63:0] res3_ff;

   assign advance   = !v3_ff || rsp.ready;
   assign req.ready = advance;

   // Decode combinational signals.
   logic        dbl, wide, neg, is_max, fz;
   logic [10:0] expf;
   logic [10:0] bias;
   logic [10:0] e_full;
   logic [5:0]  tgt;
   logic [52:0] mant;
   cls_type     cls;

   always_comb begin
      dbl  = req.data.opcode[1];
      wide = req.data.opcode[0];
      if (dbl) begin
         neg    = req.data.operand_bits[63];
         expf   = req.data.operand_bits[62:52];
         mant   = {1'b1, req.data.operand_bits[51:0]};
         fz     = req.data.operand_bits[51:0] == 52'd0;
         is_max = expf == 11'h7ff;
         bias   = 11'd1023;
      end else begin
         neg    = req.data.operand_bits[31];
         expf   = {3'd0, req.data.operand_bits[30:23]};
         mant   = {1'b1, req.data.operand_bits[22:0], 29'd0};
         fz     = req.data.operand_bits[22:0] == 23'd0;
         is_max = expf == 11'h0ff;
         bias   = 11'd127;
      end
      tgt    = wide ? 6'd63 : 6'd31;
      e_full = expf - bias;
      if (is_max) begin
         cls = fz ? CLS_SAT : CLS_ZERO;
      end else if (expf < bias) begin
         cls = CLS_ZERO;
      end else if (e_full >= {5'd0, tgt}) begin
         cls = CLS_SAT;
      end else begin
         cls = CLS_NUM;
      end
   end

   // Stage 1: classify and align the mantissa at bit 52.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req.valid;
      end
      if (advance) begin
         neg1_ff  <= neg;
         wide1_ff <= wide;
         cls1_ff  <= cls;
         mant1_ff <= mant;
         e1_ff    <= e_full[5:0];
         dbl1_ff  <= dbl;
      end
   end

   // Stage 2: shift the mantissa to form the magnitude (value = mant * 2^(e-52)).
   logic [115:0] shifted;
   always_comb begin
      shifted = {63'd0, mant1_ff} << e1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         neg2_ff  <= neg1_ff;
         wide2_ff <= wide1_ff;
         cls2_ff  <= cls1_ff;
         mag2_ff  <= shifted[114:52];
      end
   end

   // Stage 3: apply sign, saturation and zero.
   logic [63:0] res;
   always_comb begin
      case (cls2_ff)
         CLS_SAT: begin
            if (wide2_ff) res = neg2_ff ? MIN64 : MAX64;
            else          res = neg2_ff ? MIN32 : MAX32;
         end
         CLS_NUM:  res = neg2_ff ? 64'd0 - {1'b0, mag2_ff} : {1'b0, mag2_ff};
         default:  res = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         res3_ff <= res;
      end
   end

   assign rsp.valid       = v3_ff;
   assign rsp.data.result = res3_ff;

   // The output stage holds its beat while the consumer stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rsp.ready) |=> (v3_ff && $stable(res3_ff)))
      else $error("response changed during stall");

   // A 32-bit conversion always yields a sign-extended result.
   a_ext: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && advance && !wide2_ff) |=> (res3_ff[63:31] == {33{res3_ff[31]}}))
      else $error("32-bit result not sign-extended");

   // Stage valid bits advance together.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (advance && v2_ff) |=> v3_ff)
      else $error("pipeline lost a beat");

   // A single-precision value of the numeric class converted to 32 bits has an exponent below 31.
   a_dbl: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !dbl1_ff && cls1_ff == CLS_NUM) |-> (e1_ff < 6'd31 || wide1_ff))
      else $error("single exponent out of range");

endmodule
